// File: rtl/i2ew_pkg.sv
// i2ew_pkg: types and constants for the integer to english words block
// word codes, reciprocal constants for the group split, stage payload types
// no dependencies
package i2ew_pkg;

    localparam int VALUE_W   = 31;
    localparam int CODE_W    = 5;
    localparam int GROUP_W   = 10;
    localparam int Q1_W      = 22;
    localparam int Q2_W      = 12;
    localparam int NUM_GROUPS      = 4;
    localparam int SLOTS_PER_GROUP = 5;
    localparam int NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP;

    // slot offsets inside one group
    localparam int SLOT_DIGIT   = 0;
    localparam int SLOT_HUNDRED = 1;
    localparam int SLOT_TENS    = 2;
    localparam int SLOT_UNIT    = 3;
    localparam int SLOT_SCALE   = 4;

    // word codes
    localparam logic [CODE_W-1:0] W_ZERO      = 5'd0;
    localparam logic [CODE_W-1:0] W_TENS_BASE = 5'd18;
    localparam logic [CODE_W-1:0] W_HUNDRED   = 5'd28;
    localparam logic [CODE_W-1:0] W_THOUSAND  = 5'd29;
    localparam logic [CODE_W-1:0] W_MILLION   = 5'd30;
    localparam logic [CODE_W-1:0] W_BILLION   = 5'd31;

    // scale word per group, group 0 has none
    localparam logic [CODE_W-1:0] SCALE_CODE [NUM_GROUPS] =
        '{W_ZERO, W_THOUSAND, W_MILLION, W_BILLION};

    localparam logic [6:0] TEEN_MAX = 7'd19;

    // floor(x / 1000) = (x * RECIP_1000) >> 41, exact for x below 2^31
    localparam logic [31:0] RECIP_1000  = 32'd2199023256;
    localparam int          RECIP_SHIFT = 41;
    localparam int          GROUP_DIV   = 1000;
    localparam logic [Q2_W-1:0] ONE_BILLION_Q2 = 12'd1000;
    localparam logic [Q2_W-1:0] TWO_BILLION_Q2 = 12'd2000;

    // floor(g / 100) = (g * 41) >> 12 for g below 1000
    localparam logic [15:0] HUND_RECIP = 16'd41;
    localparam int          HUND_SHIFT = 12;
    // floor(r / 10) = (r * 205) >> 11 for r below 100
    localparam logic [14:0] TENS_RECIP = 15'd205;
    localparam int          TENS_SHIFT = 11;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
    } t_s1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [Q1_W-1:0]    q1;
    } t_s2;

    typedef struct packed {
        logic [Q1_W-1:0]    q1;
        logic [Q2_W-1:0]    q2;
        logic [GROUP_W-1:0] g0;
    } t_s3;

    typedef struct packed {
        logic [NUM_GROUPS-1:0][GROUP_W-1:0] grp;
    } t_s4;

    typedef struct packed {
        logic [NUM_GROUPS-1:0][3:0] hund;
        logic [NUM_GROUPS-1:0][6:0] rest;
        logic                       zero;
    } t_s5;

endpackage

// File: rtl/integer_to_english_words_top.sv
// integer_to_english_words_top: reads a 31-bit number out as a stream of word codes
// five-stage split pipeline, a slot register for the emitter, one output register
// depends on i2ew_pkg
//
// One item in, its word codes out one per cycle while i_stall is low, the final word of each
// number marked by o_last_word. An accepted item passes through the five split stages, the
// slot register and the output register. The emitter sends one word per cycle from its slot
// register unless i_stall holds it; a number has one word for zero, up to sixteen for the
// largest inputs. The pipeline in front takes a new item every cycle while it has room, and
// the next number's first word follows the previous number's last word with no gap.
module integer_to_english_words_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [i2ew_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [i2ew_pkg::CODE_W-1:0] o_word_code,
    output logic                        o_last_word
);
    import i2ew_pkg::*;

    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    t_s4 r_s4, n_s4;
    t_s5 r_s5, n_s5;
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic en1, en2, en3, en4, en5;

    logic [NUM_SLOTS-1:0]             r_mask, n_mask;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] r_codes, n_codes;
    logic [NUM_SLOTS-1:0]             new_mask;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] new_codes;
    logic [NUM_SLOTS-1:0]             pick, rest_mask;
    logic [CODE_W-1:0]                pick_code;
    logic out_load, take, emit_free, emit_load;

    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_last;

    // ---------------- group split datapath ----------------
    always_comb begin
        logic [62:0] prod1;
        prod1      = 63'(r_s1.value) * 63'(RECIP_1000);
        n_s1.value = i_value;
        n_s2.value = r_s1.value;
        n_s2.q1    = prod1[RECIP_SHIFT +: Q1_W];
    end

    always_comb begin
        logic [52:0]        prod2;
        logic [VALUE_W-1:0] rem0;
        prod2   = 53'(r_s2.q1) * 53'(RECIP_1000);
        rem0    = r_s2.value - 31'(r_s2.q1) * 31'(GROUP_DIV);
        n_s3.q1 = r_s2.q1;
        n_s3.q2 = prod2[RECIP_SHIFT +: Q2_W];
        n_s3.g0 = rem0[GROUP_W-1:0];
    end

    always_comb begin
        logic [Q1_W:0]   rem1;
        logic [1:0]      bil;
        logic [Q2_W-1:0] rem2;
        rem1 = (Q1_W+1)'(r_s3.q1) - (Q1_W+1)'(r_s3.q2) * (Q1_W+1)'(GROUP_DIV);
        if (r_s3.q2 >= TWO_BILLION_Q2) begin
            bil = 2'd2;
        end else if (r_s3.q2 >= ONE_BILLION_Q2) begin
            bil = 2'd1;
        end else begin
            bil = 2'd0;
        end
        rem2 = r_s3.q2 - Q2_W'(bil) * Q2_W'(GROUP_DIV);
        n_s4.grp[0] = r_s3.g0;
        n_s4.grp[1] = rem1[GROUP_W-1:0];
        n_s4.grp[2] = rem2[GROUP_W-1:0];
        n_s4.grp[3] = GROUP_W'(bil);
    end

    always_comb begin
        logic [15:0]        hprod;
        logic [3:0]         h;
        logic [GROUP_W-1:0] r;
        n_s5.zero = 1'b1;
        n_s5.hund = '0;
        n_s5.rest = '0;
        for (int k = 0; k < NUM_GROUPS; k++) begin
            hprod = 16'(r_s4.grp[k]) * HUND_RECIP;
            h     = hprod[HUND_SHIFT +: 4];
            r     = r_s4.grp[k] - GROUP_W'(h) * GROUP_W'(100);
            n_s5.hund[k] = h;
            n_s5.rest[k] = r[6:0];
            if (r_s4.grp[k] != '0) begin
                n_s5.zero = 1'b0;
            end
        end
    end

    // ---------------- slot build: position 0 is the billion group ----------------
    always_comb begin
        logic [14:0] tprod;
        logic [3:0]  tens;
        logic [6:0]  unit_full;
        logic [3:0]  h;
        logic [6:0]  r;
        new_mask  = '0;
        new_codes = '0;
        for (int p = 0; p < NUM_GROUPS; p++) begin
            h         = r_s5.hund[NUM_GROUPS-1-p];
            r         = r_s5.rest[NUM_GROUPS-1-p];
            tprod     = 15'(r) * TENS_RECIP;
            tens      = tprod[TENS_SHIFT +: 4];
            unit_full = r - 7'(tens) * 7'(10);
            if (h != '0) begin
                new_mask[p*SLOTS_PER_GROUP + SLOT_DIGIT]    = 1'b1;
                new_codes[p*SLOTS_PER_GROUP + SLOT_DIGIT]   = CODE_W'(h);
                new_mask[p*SLOTS_PER_GROUP + SLOT_HUNDRED]  = 1'b1;
                new_codes[p*SLOTS_PER_GROUP + SLOT_HUNDRED] = W_HUNDRED;
            end
            if (r != '0) begin
                new_mask[p*SLOTS_PER_GROUP + SLOT_TENS] = 1'b1;
                if (r <= TEEN_MAX) begin
                    new_codes[p*SLOTS_PER_GROUP + SLOT_TENS] = CODE_W'(r);
                end else begin
                    new_codes[p*SLOTS_PER_GROUP + SLOT_TENS] = W_TENS_BASE + CODE_W'(tens);
                    if (unit_full != '0) begin
                        new_mask[p*SLOTS_PER_GROUP + SLOT_UNIT]  = 1'b1;
                        new_codes[p*SLOTS_PER_GROUP + SLOT_UNIT] = CODE_W'(unit_full);
                    end
                end
            end
            if ((h != '0 || r != '0) && p != NUM_GROUPS - 1) begin
                new_mask[p*SLOTS_PER_GROUP + SLOT_SCALE]  = 1'b1;
                new_codes[p*SLOTS_PER_GROUP + SLOT_SCALE] = SCALE_CODE[NUM_GROUPS-1-p];
            end
        end
        if (r_s5.zero) begin
            new_mask[0]  = 1'b1;
            new_codes[0] = W_ZERO;
        end
    end

    // ---------------- emitter ----------------
    always_comb begin
        out_load  = !r_out_valid || !i_stall;
        take      = out_load && (r_mask != '0);
        pick      = r_mask & (~r_mask + NUM_SLOTS'(1));
        rest_mask = r_mask & ~pick;
        pick_code = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (pick[s]) begin
                pick_code = pick_code | r_codes[s];
            end
        end
        emit_free = (r_mask == '0) || (take && rest_mask == '0);
        emit_load = r_s5_vld && emit_free;
        if (emit_load) begin
            n_mask  = new_mask;
            n_codes = new_codes;
        end else if (take) begin
            n_mask  = rest_mask;
            n_codes = r_codes;
        end else begin
            n_mask  = r_mask;
            n_codes = r_codes;
        end
    end

    // stage enables: a stage loads when empty or when its item moves on
    always_comb begin
        en5 = !r_s5_vld || emit_free;
        en4 = !r_s4_vld || en5;
        en3 = !r_s3_vld || en4;
        en2 = !r_s2_vld || en3;
        en1 = !r_s1_vld || en2;
    end

    assign o_stall     = !en1;
    assign o_valid     = r_out_valid;
    assign o_word_code = r_out_code;
    assign o_last_word = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_s5_vld    <= 1'b0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) r_s1_vld <= i_valid;
            if (en2) r_s2_vld <= r_s1_vld;
            if (en3) r_s3_vld <= r_s2_vld;
            if (en4) r_s4_vld <= r_s3_vld;
            if (en5) r_s5_vld <= r_s4_vld;
            r_mask <= n_mask;
            if (out_load) r_out_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
        if (en2) r_s2 <= n_s2;
        if (en3) r_s3 <= n_s3;
        if (en4) r_s4 <= n_s4;
        if (en5) r_s5 <= n_s5;
        r_codes <= n_codes;
        if (out_load) begin
            r_out_code <= pick_code;
            r_out_last <= (rest_mask == '0);
        end
    end

    // ---------------- assertions ----------------
    a_words_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) <= 16)
        else $error("more than sixteen words pending for one item");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_mask != '0))
        else $error("word not marked last but nothing left to send");

    a_zero_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_code == W_ZERO) |-> r_out_last)
        else $error("zero word not alone in its item");

endmodule

// File: test/integer_to_english_words_top_test.sv
// integer_to_english_words_top_test: self-checking bench for integer_to_english_words_top
// predicts the word codes of each number and checks them in order under varied flow control
// depends on i2ew_pkg and the block's rtl
`timescale 1ns / 100ps

module integer_to_english_words_top_test;
    import i2ew_pkg::*;

    localparam int QUIET_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 24;
    localparam logic [VALUE_W-1:0] MAX_VALUE = 31'h7fffffff;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_spoken_word;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic                 i_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [CODE_W-1:0]    o_word_code;
    logic                 o_last_word;

    logic [VALUE_W-1:0]   numbers_to_send [$];
    t_spoken_word         words_due [$];
    logic                 item_taken = 1'b0;
    int                   numbers_queued = 0;
    int                   numbers_taken  = 0;
    int                   words_checked  = 0;
    int                   mismatches     = 0;
    int                   quiet_cycles   = 0;
    int                   send_idle_pct  = 0;
    int                   stall_pct      = 0;

    integer_to_english_words_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // one three-digit group, then its scale word when it has one
    function automatic void say_group(input int g, input logic has_scale,
                                      input logic [CODE_W-1:0] scale,
                                      ref logic [CODE_W-1:0] words [$]);
        int hund;
        int rest;
        hund = g / 100;
        rest = g % 100;
        if (g == 0)
            return;
        if (hund != 0) begin
            words.push_back(CODE_W'(hund));
            words.push_back(W_HUNDRED);
        end
        if (rest != 0) begin
            if (rest <= 19) begin
                words.push_back(CODE_W'(rest));
            end else begin
                words.push_back(W_TENS_BASE + CODE_W'(rest / 10));
                if (rest % 10 != 0)
                    words.push_back(CODE_W'(rest % 10));
            end
        end
        if (has_scale)
            words.push_back(scale);
    endfunction

    function automatic void spell_number(input logic [VALUE_W-1:0] n);
        logic [CODE_W-1:0] words [$];
        longint v;
        t_spoken_word w;
        v = longint'(n);
        if (v == 0) begin
            words.push_back(W_ZERO);
        end else begin
            say_group(int'(v / 1000000000), 1'b1, W_BILLION, words);
            say_group(int'((v / 1000000) % 1000), 1'b1, W_MILLION, words);
            say_group(int'((v / 1000) % 1000), 1'b1, W_THOUSAND, words);
            say_group(int'(v % 1000), 1'b0, W_ZERO, words);
        end
        foreach (words[k]) begin
            w.code = words[k];
            w.last = (k == words.size() - 1);
            words_due.push_back(w);
        end
    endfunction

    // half of the numbers built group by group so zero groups, teens and round tens show up often
    function automatic logic [VALUE_W-1:0] pick_number();
        longint v;
        int g;
        v = 0;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                for (int k = 0; k < 4; k++) begin
                    case ($urandom_range(3))
                        0: g = 0;
                        1: g = $urandom_range(1, 19);
                        2: g = $urandom_range(999);
                        default: g = $urandom_range(9) * 100 + $urandom_range(2, 9) * 10;
                    endcase
                    if (k == 3)
                        g = g % 3;
                    v = v + longint'(g) * (k == 0 ? 1 : k == 1 ? 1000 :
                                           k == 2 ? 1000000 : 1000000000);
                end
            end
            5, 6: v = longint'($urandom());
            7: v = $urandom_range(999);
            8: v = $urandom_range(99);
            default: v = longint'($urandom_range(999)) * 1000000;
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // driver: a held item stays until taken, idle only between items
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || item_taken) begin
            if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_value <= numbers_to_send.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_spoken_word want;
        item_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                spell_number(i_value);
                numbers_taken <= numbers_taken + 1;
            end
            if (o_valid && !i_stall) begin
                words_checked <= words_checked + 1;
                if (words_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected word: code %0d last %0b",
                                 o_word_code, o_last_word);
                end else begin
                    want = words_due.pop_front();
                    if (want.code !== o_word_code || want.last !== o_last_word) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("word %0d: expected code %0d last %0b, got code %0d last %0b",
                                     words_checked, want.code, want.last,
                                     o_word_code, o_last_word);
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout with %0d words outstanding", words_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int idle_plan [4];
        int stall_plan [4];
        logic [VALUE_W-1:0] directed [$];
        idle_plan  = '{0, 69, 0, 19};
        stall_plan = '{0, 0, 69, 19};
        directed = '{31'd0, 31'd1, 31'd7, 31'd13, 31'd19, 31'd20, 31'd21, 31'd99,
                     31'd100, 31'd101, 31'd110, 31'd119, 31'd999, 31'd1000, 31'd1001,
                     31'd1000000, 31'd1000000000, 31'd2000000000, 31'd1010101010,
                     31'd999999999, 31'd13013013, 31'd1777777777, 31'd40050060,
                     MAX_VALUE};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 4; p++) begin
            @(posedge i_clk);
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            if (p == 0) begin
                foreach (directed[k]) begin
                    numbers_to_send.push_back(directed[k]);
                    numbers_queued++;
                end
            end
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                numbers_to_send.push_back(pick_number());
                numbers_queued++;
            end
            // hold off the next phase until every word of this one is back
            do @(negedge i_clk);
            while (numbers_taken != numbers_queued || words_due.size() != 0);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (words_due.size() != 0)
            mismatches = mismatches + words_due.size();
        $display("checked %0d words from %0d numbers over four flow-control phases",
                 words_checked, numbers_taken);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/i2ew_pkg.sv
rtl/integer_to_english_words_top.sv
test/integer_to_english_words_top_test.sv
